[rtl/sipr_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and helper functions of the scan isolated point remover.
// Used by sipr_filter, sipr_outq and scan_isolated_point_remover_top; no dependencies.

package sipr_pkg;

   localparam int RangeW   = 16;
   localparam int IntensW  = 16;
   localparam int KindW    = 2;
   localparam int CsrIdxW  = 2;
   localparam int OutqDepth = 4;
   localparam int OutqPtrW  = $clog2(OutqDepth);
   localparam int OutqLevelW = $clog2(OutqDepth + 1);

   localparam logic [KindW-1:0] KindFinite = 2'd0;
   localparam logic [KindW-1:0] KindPosInf = 2'd1;
   localparam logic [KindW-1:0] KindNegInf = 2'd2;
   localparam logic [KindW-1:0] KindNan    = 2'd3;

   localparam logic [CsrIdxW-1:0] CsrOutlierThreshold = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrRangeLowerLimit  = 2'd1;
   localparam logic [CsrIdxW-1:0] CsrRangeUpperLimit  = 2'd2;

   localparam logic [RangeW-1:0] ThresholdReset  = 16'd100;
   localparam logic [RangeW-1:0] LowerLimitReset = 16'd0;
   localparam logic [RangeW-1:0] UpperLimitReset = 16'hFFFF;

   typedef struct packed {
      logic [RangeW-1:0] threshold;
      logic [RangeW-1:0] lower;
      logic [RangeW-1:0] upper;
   } cfg_type;

   typedef struct packed {
      logic [RangeW-1:0]  range_mm;
      logic [KindW-1:0]   kind;
      logic [IntensW-1:0] intensity;
      logic               has_intensity;
      logic               last;
   } result_type;

   // True when the neighbor is infinite, or is finite and differs from the value by more than the threshold.
   function automatic logic exceeds(input logic [RangeW-1:0] cur,
                                    input logic [RangeW-1:0] nr,
                                    input logic [KindW-1:0]  nk,
                                    input logic [RangeW-1:0] thr);
      logic [RangeW-1:0] diff;
      logic              res;
      diff = (cur >= nr) ? (cur - nr) : (nr - cur);
      case (nk)
         KindPosInf: res = 1'b1;
         KindNegInf: res = 1'b1;
         KindNan:    res = 1'b0;
         default:    res = (diff > thr);
      endcase
      return res;
   endfunction

endpackage

[rtl/sipr_filter.sv]
`timescale 1ns / 1ps
// Scan state and isolated point decision for one incoming item per cycle while accept is high.
// Depends on sipr_pkg.

module sipr_filter (
   input  logic                            clock,
   input  logic                            reset,
   input  sipr_pkg::cfg_type               cfg,
   input  logic                            accept,
   input  logic [sipr_pkg::RangeW-1:0]     range_mm,
   input  logic [sipr_pkg::KindW-1:0]      range_kind,
   input  logic [sipr_pkg::IntensW-1:0]    intensity,
   input  logic                            has_intensity,
   input  logic                            scan_last,
   output logic [1:0]                      push_cnt,
   output sipr_pkg::result_type            res0,
   output sipr_pkg::result_type            res1
);

   localparam logic [1:0] PosStart    = 2'd0;
   localparam logic [1:0] PosFirst    = 2'd1;
   localparam logic [1:0] PosInterior = 2'd2;

   logic [1:0]                     pos_ff, pos_in;
   logic [sipr_pkg::RangeW-1:0]    left_range_ff, left_range_in;
   logic [sipr_pkg::KindW-1:0]     left_kind_ff, left_kind_in;
   logic [sipr_pkg::RangeW-1:0]    held_range_ff, held_range_in;
   logic [sipr_pkg::KindW-1:0]     held_kind_ff, held_kind_in;
   logic [sipr_pkg::IntensW-1:0]   held_intensity_ff, held_intensity_in;
   logic                           held_has_ff, held_has_in;

   logic [sipr_pkg::RangeW-1:0]    cur_range;
   logic                           held_valid;
   logic                           remove;
   sipr_pkg::result_type           cur_res;
   sipr_pkg::result_type           held_res;

   always_comb begin
      cur_range = (range_kind == sipr_pkg::KindFinite) ? range_mm : '0;

      cur_res.range_mm      = cur_range;
      cur_res.kind          = range_kind;
      cur_res.intensity     = has_intensity ? intensity : '0;
      cur_res.has_intensity = has_intensity;
      cur_res.last          = 1'b1;

      held_valid = (held_kind_ff == sipr_pkg::KindFinite) &&
                   (held_range_ff >= cfg.lower) && (held_range_ff <= cfg.upper);
      remove = (pos_ff != PosFirst) && held_valid &&
               sipr_pkg::exceeds(held_range_ff, left_range_ff, left_kind_ff,
                                 cfg.threshold) &&
               sipr_pkg::exceeds(held_range_ff, cur_range, range_kind, cfg.threshold);

      held_res.range_mm      = remove ? '0 : held_range_ff;
      held_res.kind          = remove ? sipr_pkg::KindPosInf : held_kind_ff;
      held_res.intensity     = (remove || !held_has_ff) ? '0 : held_intensity_ff;
      held_res.has_intensity = held_has_ff;
      held_res.last          = 1'b0;

      pos_in            = pos_ff;
      left_range_in     = left_range_ff;
      left_kind_in      = left_kind_ff;
      held_range_in     = held_range_ff;
      held_kind_in      = held_kind_ff;
      held_intensity_in = held_intensity_ff;
      held_has_in       = held_has_ff;
      res1              = cur_res;

      case (pos_ff)
         PosStart: begin
            res0     = cur_res;
            push_cnt = scan_last ? 2'd1 : 2'd0;
         end
         default: begin
            res0          = held_res;
            push_cnt      = scan_last ? 2'd2 : 2'd1;
            left_range_in = held_res.range_mm;
            left_kind_in  = held_res.kind;
         end
      endcase

      if (scan_last) begin
         pos_in = PosStart;
      end else begin
         pos_in            = (pos_ff == PosStart) ? PosFirst : PosInterior;
         held_range_in     = cur_range;
         held_kind_in      = range_kind;
         held_intensity_in = intensity;
         held_has_in       = has_intensity;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff            <= PosStart;
         left_range_ff     <= '0;
         left_kind_ff      <= '0;
         held_range_ff     <= '0;
         held_kind_ff      <= '0;
         held_intensity_ff <= '0;
         held_has_ff       <= 1'b0;
      end else if (accept) begin
         pos_ff            <= pos_in;
         left_range_ff     <= left_range_in;
         left_kind_ff      <= left_kind_in;
         held_range_ff     <= held_range_in;
         held_kind_ff      <= held_kind_in;
         held_intensity_ff <= held_intensity_in;
         held_has_ff       <= held_has_in;
      end
   end

endmodule

[rtl/sipr_outq.sv]
`timescale 1ns / 1ps
// Result queue of four registered entries that takes up to two results per cycle.
// Depends on sipr_pkg.

module sipr_outq (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [1:0]                          push_cnt,
   input  sipr_pkg::result_type                wr0,
   input  sipr_pkg::result_type                wr1,
   input  logic                                pop,
   output sipr_pkg::result_type                head,
   output logic [sipr_pkg::OutqLevelW-1:0]     level
);

   sipr_pkg::result_type                  entries_ff [sipr_pkg::OutqDepth];
   logic [sipr_pkg::OutqPtrW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [sipr_pkg::OutqPtrW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [sipr_pkg::OutqLevelW-1:0]       level_ff, level_in;
   logic [sipr_pkg::OutqPtrW-1:0]         wr_ptr_next;

   assign wr_ptr_next = wr_ptr_ff + sipr_pkg::OutqPtrW'(1);
   assign head        = entries_ff[rd_ptr_ff];
   assign level       = level_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + sipr_pkg::OutqPtrW'(push_cnt);
      rd_ptr_in = rd_ptr_ff + sipr_pkg::OutqPtrW'(pop);
      level_in  = level_ff + sipr_pkg::OutqLevelW'(push_cnt)
                  - sipr_pkg::OutqLevelW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         entries_ff[wr_ptr_ff] <= wr0;
      end
      if (push_cnt == 2'd2) begin
         entries_ff[wr_ptr_next] <= wr1;
      end
   end

endmodule

[rtl/scan_isolated_point_remover_top.sv]
`timescale 1ns / 1ps
// Top level of the scan isolated point remover: configuration registers and channels.
// Depends on sipr_pkg, sipr_filter and sipr_outq.
//
// The req_ channel carries one range sample of a lidar scan per item, with
// req_scan_last on the final sample. The rsp_ channel returns one filtered
// sample per item, in scan order, with rsp_out_last on the final one.
// Results lag the input by one sample: the first sample of a scan of two or
// more gives no result, and its last sample gives two, its predecessor and
// itself; a one-sample scan gives one. A result reaches rsp_ through the
// registered result queue. One item is accepted per cycle while the result
// queue of four entries holds at most two results, so a receiver that takes
// one item per cycle sees a sustained rate of one item per cycle.
// When the receiver stalls, results collect in the queue and req_ready
// drops once fewer than two entries are free; nothing is lost.
// Reset clears the queue and the scan position and loads the threshold to
// 100 mm and the range limits to 0 and 65535 mm. The csr_ port writes a
// register while csr_we is high and must only be used while the block is idle.

module scan_isolated_point_remover_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [sipr_pkg::RangeW-1:0]         req_range_mm,
   input  logic [sipr_pkg::KindW-1:0]          req_range_kind,
   input  logic [sipr_pkg::IntensW-1:0]        req_intensity,
   input  logic                                req_has_intensity,
   input  logic                                req_scan_last,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [sipr_pkg::RangeW-1:0]         rsp_out_range_mm,
   output logic [sipr_pkg::KindW-1:0]          rsp_out_kind,
   output logic [sipr_pkg::IntensW-1:0]        rsp_out_intensity,
   output logic                                rsp_out_has_intensity,
   output logic                                rsp_out_last,
   input  logic                                csr_we,
   input  logic [sipr_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [sipr_pkg::RangeW-1:0]         csr_wdata
);

   sipr_pkg::cfg_type                     cfg_ff;
   logic                                  accept;
   logic                                  pop;
   logic [1:0]                            push_cnt;
   sipr_pkg::result_type                  res0;
   sipr_pkg::result_type                  res1;
   sipr_pkg::result_type                  head;
   logic [sipr_pkg::OutqLevelW-1:0]       level;

   assign req_ready = (level <= sipr_pkg::OutqLevelW'(sipr_pkg::OutqDepth - 2));
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (level != '0);
   assign pop       = rsp_valid && rsp_ready;

   assign rsp_out_range_mm      = head.range_mm;
   assign rsp_out_kind          = head.kind;
   assign rsp_out_intensity     = head.intensity;
   assign rsp_out_has_intensity = head.has_intensity;
   assign rsp_out_last          = head.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold <= sipr_pkg::ThresholdReset;
         cfg_ff.lower     <= sipr_pkg::LowerLimitReset;
         cfg_ff.upper     <= sipr_pkg::UpperLimitReset;
      end else if (csr_we) begin
         case (csr_index)
            sipr_pkg::CsrOutlierThreshold: cfg_ff.threshold <= csr_wdata;
            sipr_pkg::CsrRangeLowerLimit:  cfg_ff.lower     <= csr_wdata;
            sipr_pkg::CsrRangeUpperLimit:  cfg_ff.upper     <= csr_wdata;
            default: ;
         endcase
      end
   end

   sipr_filter u_filter (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .accept        (accept),
      .range_mm      (req_range_mm),
      .range_kind    (req_range_kind),
      .intensity     (req_intensity),
      .has_intensity (req_has_intensity),
      .scan_last     (req_scan_last),
      .push_cnt      (push_cnt),
      .res0          (res0),
      .res1          (res1)
   );

   sipr_outq u_outq (
      .clock    (clock),
      .reset    (reset),
      .push_cnt (accept ? push_cnt : 2'd0),
      .wr0      (res0),
      .wr1      (res1),
      .pop      (pop),
      .head     (head),
      .level    (level)
   );

   // The queue never holds more entries than it has.
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level <= sipr_pkg::OutqLevelW'(sipr_pkg::OutqDepth))
      else $error("result queue overflow");

   // The last sample of a scan always yields a result in the next cycle.
   a_last_yields: assert property (@(posedge clock) disable iff (reset)
      (accept && req_scan_last) |=> rsp_valid)
      else $error("no result after last sample of scan");

   // A result cannot appear from an empty queue without an accepted item.
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      (!accept && (level == '0)) |=> !rsp_valid)
      else $error("result appeared without an accepted item");

endmodule

[bench/scan_isolated_point_remover_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of scan_isolated_point_remover_top: a directed table and random scans
// under several register settings, checked against an in-bench filter of the scan stream.
// Depends on sipr_pkg and scan_isolated_point_remover_top.

module testbench;

   localparam logic [sipr_pkg::CsrIdxW-1:0] CsrUnused = 2'd3;
   localparam int ItemsPerPhase = 180;
   localparam int NumPhases = 7;
   localparam int SettleCycles = 4;
   localparam int DrainCycles = 8;
   localparam int WatchLimit = 2000;
   localparam int HoldOffCycles = 80;

   typedef enum logic [1:0] {ScanStart, FirstHeld, CandidateHeld} scan_pos_type;

   typedef struct packed {
      logic [sipr_pkg::RangeW-1:0]  range_mm;
      logic [sipr_pkg::KindW-1:0]   kind;
      logic [sipr_pkg::IntensW-1:0] intensity;
      logic                         has_intensity;
      logic                         last;
   } sample_type;

   typedef struct packed {
      sample_type           sample;
      logic                 typed;
      sipr_pkg::result_type result;
   } table_row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [sipr_pkg::RangeW-1:0] req_range_mm;
   logic [sipr_pkg::KindW-1:0] req_range_kind;
   logic [sipr_pkg::IntensW-1:0] req_intensity;
   logic req_has_intensity;
   logic req_scan_last;
   logic rsp_valid;
   logic rsp_ready;
   logic [sipr_pkg::RangeW-1:0] rsp_out_range_mm;
   logic [sipr_pkg::KindW-1:0] rsp_out_kind;
   logic [sipr_pkg::IntensW-1:0] rsp_out_intensity;
   logic rsp_out_has_intensity;
   logic rsp_out_last;
   logic csr_we;
   logic [sipr_pkg::CsrIdxW-1:0] csr_index;
   logic [sipr_pkg::RangeW-1:0] csr_wdata;

   sipr_pkg::cfg_type shadow_cfg;
   scan_pos_type scan_pos;
   sample_type held;
   logic [sipr_pkg::RangeW-1:0] left_range;
   logic [sipr_pkg::KindW-1:0] left_kind;
   sipr_pkg::result_type due_filtered[$];
   table_row_type directed_table[$];

   int failures = 0;
   int quiet_cycles = 0;
   bit quiet_mode = 1'b0;
   bit hold_off_requested = 1'b0;
   int hold_off_left = 0;

   scan_isolated_point_remover_top dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_range_mm          (req_range_mm),
      .req_range_kind        (req_range_kind),
      .req_intensity         (req_intensity),
      .req_has_intensity     (req_has_intensity),
      .req_scan_last         (req_scan_last),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_out_range_mm      (rsp_out_range_mm),
      .rsp_out_kind          (rsp_out_kind),
      .rsp_out_intensity     (rsp_out_intensity),
      .rsp_out_has_intensity (rsp_out_has_intensity),
      .rsp_out_last          (rsp_out_last),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic sipr_pkg::result_type make_result(
         input logic [sipr_pkg::RangeW-1:0] r,
         input logic [sipr_pkg::KindW-1:0] k,
         input logic [sipr_pkg::IntensW-1:0] i,
         input logic h,
         input logic l);
      sipr_pkg::result_type res;
      res.range_mm = (k == sipr_pkg::KindFinite) ? r : '0;
      res.kind = k;
      res.intensity = h ? i : '0;
      res.has_intensity = h;
      res.last = l;
      return res;
   endfunction

   function automatic logic outlying(input logic [sipr_pkg::RangeW-1:0] cur,
                                     input logic [sipr_pkg::RangeW-1:0] nr,
                                     input logic [sipr_pkg::KindW-1:0] nk);
      logic [sipr_pkg::RangeW-1:0] gap;
      logic res;
      gap = (cur >= nr) ? (cur - nr) : (nr - cur);
      if (nk == sipr_pkg::KindPosInf || nk == sipr_pkg::KindNegInf) begin
         res = 1'b1;
      end else if (nk == sipr_pkg::KindNan) begin
         res = 1'b0;
      end else begin
         res = gap > shadow_cfg.threshold;
      end
      return res;
   endfunction

   // Advances the scan state by one accepted item and queues the filtered samples it releases.
   function automatic void filter_sample(input sample_type s);
      logic [sipr_pkg::RangeW-1:0] r;
      logic [sipr_pkg::RangeW-1:0] fr;
      logic [sipr_pkg::KindW-1:0] fk;
      logic [sipr_pkg::IntensW-1:0] fi;
      logic checked;
      r = (s.kind == sipr_pkg::KindFinite) ? s.range_mm : '0;
      if (scan_pos == ScanStart) begin
         if (s.last) begin
            due_filtered.push_back(make_result(r, s.kind, s.intensity, s.has_intensity, 1'b1));
         end else begin
            held = s;
            held.range_mm = r;
            scan_pos = FirstHeld;
         end
      end else begin
         fr = held.range_mm;
         fk = held.kind;
         fi = held.intensity;
         if (scan_pos != FirstHeld) begin
            checked = held.kind == sipr_pkg::KindFinite &&
                      held.range_mm >= shadow_cfg.lower &&
                      held.range_mm <= shadow_cfg.upper;
            if (checked && outlying(fr, left_range, left_kind) && outlying(fr, r, s.kind)) begin
               fr = '0;
               fk = sipr_pkg::KindPosInf;
               fi = '0;
            end
         end
         due_filtered.push_back(make_result(fr, fk, fi, held.has_intensity, 1'b0));
         left_range = fr;
         left_kind = fk;
         if (s.last) begin
            due_filtered.push_back(make_result(r, s.kind, s.intensity, s.has_intensity, 1'b1));
            scan_pos = ScanStart;
         end else begin
            held = s;
            held.range_mm = r;
            scan_pos = CandidateHeld;
         end
      end
   endfunction

   function automatic void add_row(input logic [sipr_pkg::RangeW-1:0] r,
                                   input logic [sipr_pkg::KindW-1:0] k,
                                   input logic [sipr_pkg::IntensW-1:0] i,
                                   input logic h, input logic l);
      table_row_type row;
      row = '0;
      row.sample = '{r, k, i, h, l};
      directed_table.push_back(row);
   endfunction

   function automatic void add_single(input logic [sipr_pkg::RangeW-1:0] r,
                                      input logic [sipr_pkg::KindW-1:0] k,
                                      input logic [sipr_pkg::IntensW-1:0] i, input logic h,
                                      input logic [sipr_pkg::RangeW-1:0] er,
                                      input logic [sipr_pkg::KindW-1:0] ek,
                                      input logic [sipr_pkg::IntensW-1:0] ei, input logic eh);
      table_row_type row;
      row.sample = '{r, k, i, h, 1'b1};
      row.typed = 1'b1;
      row.result = '{er, ek, ei, eh, 1'b1};
      directed_table.push_back(row);
   endfunction

   task automatic send_sample(input sample_type s);
      @(negedge clock);
      while (!quiet_mode && $urandom_range(0, 99) < 6) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_range_mm <= s.range_mm;
      req_range_kind <= s.kind;
      req_intensity <= s.intensity;
      req_has_intensity <= s.has_intensity;
      req_scan_last <= s.last;
      do @(posedge clock); while (!req_ready);
      filter_sample(s);
   endtask

   task automatic write_csr(input logic [sipr_pkg::CsrIdxW-1:0] idx,
                            input logic [sipr_pkg::RangeW-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         sipr_pkg::CsrOutlierThreshold: shadow_cfg.threshold = value;
         sipr_pkg::CsrRangeLowerLimit:  shadow_cfg.lower = value;
         sipr_pkg::CsrRangeUpperLimit:  shadow_cfg.upper = value;
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      while (due_filtered.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic send_random_scan(input int len);
      sample_type s;
      int base;
      int v;
      int sel;
      base = $urandom_range(0, 65535);
      for (int n = 0; n < len; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 60) begin
            v = base + int'($urandom_range(0, 500)) - 250;
            v = (v < 0) ? 0 : (v > 65535) ? 65535 : v;
         end else if (sel < 85) begin
            v = $urandom_range(0, 65535);
         end else begin
            v = (sel[0]) ? 65535 : 0;
         end
         s.range_mm = v[sipr_pkg::RangeW-1:0];
         s.kind = ($urandom_range(0, 99) < 85) ? sipr_pkg::KindFinite :
                  sipr_pkg::KindW'($urandom_range(1, 3));
         s.intensity = sipr_pkg::IntensW'($urandom_range(0, 65535));
         s.has_intensity = 1'($urandom_range(0, 1));
         s.last = (n == len - 1);
         send_sample(s);
      end
   endtask

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   always @(negedge clock) begin
      if (hold_off_requested) begin
         hold_off_requested = 1'b0;
         hold_off_left = HoldOffCycles;
      end
      if (hold_off_left != 0) begin
         hold_off_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= quiet_mode || ($urandom_range(0, 99) >= 6);
      end
   end

   always @(posedge clock) begin : check_results
      sipr_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_filtered.size() == 0) begin
            $error("unexpected result: range %0d kind %0d", rsp_out_range_mm, rsp_out_kind);
            failures++;
         end else begin
            want = due_filtered.pop_front();
            check_field("out_range_mm", int'(want.range_mm), int'(rsp_out_range_mm));
            check_field("out_kind", int'(want.kind), int'(rsp_out_kind));
            check_field("out_intensity", int'(want.intensity), int'(rsp_out_intensity));
            check_field("out_has_intensity", int'(want.has_intensity),
                        int'(rsp_out_has_intensity));
            check_field("out_last", int'(want.last), int'(rsp_out_last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WatchLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      int items_in_phase;
      int len;
      int sel;
      bit hold_off_done;
      logic [sipr_pkg::RangeW-1:0] thr;
      logic [sipr_pkg::RangeW-1:0] lo;
      logic [sipr_pkg::RangeW-1:0] hi;

      hold_off_done = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_range_mm = '0;
      req_range_kind = sipr_pkg::KindFinite;
      req_intensity = '0;
      req_has_intensity = 1'b0;
      req_scan_last = 1'b0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = sipr_pkg::CsrOutlierThreshold;
      csr_wdata = '0;
      shadow_cfg = '{sipr_pkg::ThresholdReset, sipr_pkg::LowerLimitReset,
                     sipr_pkg::UpperLimitReset};
      scan_pos = ScanStart;
      held = '0;
      left_range = '0;
      left_kind = sipr_pkg::KindFinite;

      // Single-sample scans come back at once; removal, thresholds and neighbor kinds follow.
      add_single(16'd65535, sipr_pkg::KindFinite, 16'hFFFF, 1'b1,
                 16'd65535, sipr_pkg::KindFinite, 16'hFFFF, 1'b1);
      add_single(16'h1234, sipr_pkg::KindNan, 16'h0055, 1'b0,
                 16'd0, sipr_pkg::KindNan, 16'd0, 1'b0);
      add_single(16'hFFFF, sipr_pkg::KindPosInf, 16'hABCD, 1'b1,
                 16'd0, sipr_pkg::KindPosInf, 16'hABCD, 1'b1);
      add_single(16'd0, sipr_pkg::KindNegInf, 16'd0, 1'b1,
                 16'd0, sipr_pkg::KindNegInf, 16'd0, 1'b1);
      add_row(16'd0, sipr_pkg::KindFinite, 16'd0, 1'b1, 1'b0);
      add_row(16'd65535, sipr_pkg::KindFinite, 16'hFFFF, 1'b1, 1'b1);
      add_row(16'd1000, sipr_pkg::KindFinite, 16'd7, 1'b1, 1'b0);
      add_row(16'd5000, sipr_pkg::KindFinite, 16'd8, 1'b1, 1'b0);
      add_row(16'd9000, sipr_pkg::KindFinite, 16'd9, 1'b0, 1'b0);
      add_row(16'd1000, sipr_pkg::KindFinite, 16'd10, 1'b1, 1'b1);
      add_row(16'd77, sipr_pkg::KindPosInf, 16'd1, 1'b1, 1'b0);
      add_row(16'd3000, sipr_pkg::KindFinite, 16'd2, 1'b1, 1'b0);
      add_row(16'd0, sipr_pkg::KindNegInf, 16'd3, 1'b1, 1'b1);
      add_row(16'd0, sipr_pkg::KindNan, 16'd4, 1'b1, 1'b0);
      add_row(16'd3000, sipr_pkg::KindFinite, 16'd5, 1'b1, 1'b0);
      add_row(16'd9000, sipr_pkg::KindFinite, 16'd6, 1'b1, 1'b1);
      add_row(16'd1000, sipr_pkg::KindFinite, 16'hFFFF, 1'b1, 1'b0);
      add_row(16'd1100, sipr_pkg::KindFinite, 16'h8000, 1'b1, 1'b0);
      add_row(16'd1200, sipr_pkg::KindFinite, 16'h0001, 1'b1, 1'b1);
      add_row(16'd1000, sipr_pkg::KindFinite, 16'd11, 1'b0, 1'b0);
      add_row(16'd1101, sipr_pkg::KindFinite, 16'd12, 1'b1, 1'b0);
      add_row(16'd1000, sipr_pkg::KindFinite, 16'd13, 1'b1, 1'b1);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_table[n]) begin
         send_sample(directed_table[n].sample);
         if (directed_table[n].typed) begin
            due_filtered[due_filtered.size() - 1] = directed_table[n].result;
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;

      for (int phase = 0; phase < NumPhases; phase++) begin
         wait_idle();
         case (phase)
            0: begin thr = 16'd100; lo = 16'd0; hi = 16'd65535; end
            1: begin thr = 16'd0; lo = 16'd0; hi = 16'd65535; end
            2: begin thr = 16'd65535; lo = 16'd0; hi = 16'd65535; end
            3: begin thr = 16'd50; lo = 16'd2000; hi = 16'd60000; end
            4: begin thr = 16'd100; lo = 16'd40000; hi = 16'd1000; end
            5: begin
               thr = sipr_pkg::RangeW'($urandom_range(1, 300));
               lo = sipr_pkg::RangeW'($urandom_range(0, 30000));
               hi = lo + sipr_pkg::RangeW'($urandom_range(0, 30000));
            end
            default: begin thr = 16'd100; lo = 16'd65535; hi = 16'd65535; end
         endcase
         write_csr(sipr_pkg::CsrOutlierThreshold, thr);
         write_csr(sipr_pkg::CsrRangeLowerLimit, lo);
         write_csr(sipr_pkg::CsrRangeUpperLimit, hi);
         write_csr(CsrUnused, sipr_pkg::RangeW'($urandom_range(0, 65535)));
         quiet_mode = (phase == 2);
         items_in_phase = 0;
         while (items_in_phase < ItemsPerPhase) begin
            if (!hold_off_done && items_in_phase >= 60) begin
               hold_off_requested = 1'b1;
               hold_off_done = 1'b1;
            end
            sel = $urandom_range(0, 99);
            if (sel < 10) begin
               len = 1;
            end else if (sel < 20) begin
               len = 2;
            end else if (sel < 90) begin
               len = $urandom_range(3, 12);
            end else begin
               len = $urandom_range(13, 40);
            end
            send_random_scan(len);
            items_in_phase += len;
         end
         @(negedge clock);
         req_valid <= 1'b0;
      end
      quiet_mode = 1'b0;

      while (due_filtered.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (due_filtered.size() != 0) begin
         $error("%0d expected results never arrived", due_filtered.size());
         failures++;
      end
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
